// ----- hdl/array_search_insert_delete_unit_assert.svh -----
// assertion macros for the array search, insert and delete unit
// needs clk and arst_n in the scope where a macro is used
`ifndef ARRAY_SEARCH_INSERT_DELETE_UNIT_ASSERT_SVH
`define ARRAY_SEARCH_INSERT_DELETE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ASID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// consequent must hold in the cycle after the antecedent
`define ASID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

// ----- hdl/asid_pkg.sv -----
// shared constants, codes and helper functions of the array search unit
// no dependencies
package asid_pkg;

	// storage geometry
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int BND_W      = CNT_W + 1;

	// transaction field widths
	localparam int OP_W    = 3;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 7;
	localparam int ST_W    = 2;
	localparam int INDEX_W = 6;
	localparam int ELEM_W  = 32;
	localparam int TOTAL_W = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_LINEAR = 3'd0;
	localparam logic [OP_W-1:0] OP_BINARY = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

	typedef logic [DATA_WIDTH-1:0] data_t;

	// sign-extend the key field and wrap it to the storage width
	function automatic data_t fit_key(input logic [KEY_W-1:0] key);
		logic [63:0] wide;
		wide = 64'(signed'(key));
		return wide[DATA_WIDTH-1:0];
	endfunction

	// stored entry as seen on the element field
	function automatic logic [ELEM_W-1:0] elem_of(input data_t d);
		logic [63:0] wide;
		wide = 64'(signed'(d));
		return wide[ELEM_W-1:0];
	endfunction

endpackage

// ----- hdl/asid_if.sv -----
// request and response channel interfaces of the array search unit
// depends on asid_pkg
interface asid_req_if import asid_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [KEY_W-1:0]  key_or_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, op, key_or_value, position, input ready);
	modport sink (input valid, op, key_or_value, position, output ready);
endinterface

interface asid_rsp_if import asid_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [ST_W-1:0]           status;
	logic [INDEX_W-1:0]        index;
	logic signed [ELEM_W-1:0]  element;
	logic [TOTAL_W-1:0]        entry_total;

	modport source (output valid, status, index, element, entry_total, input ready);
	modport sink (input valid, status, index, element, entry_total, output ready);
endinterface

// ----- hdl/array_search_insert_delete_unit.sv -----
// one transaction at a time; every step goes through an entry memory with separate read and
// write ports and a registered read; a shift during insert or delete writes one entry while it
// reads the next, an append skips the shift, and a rejected request goes straight to the
// response; a finished response waits in an output register while the next
// request is taken, and a full output register holds the sequencer in its last state
// arst_n clears the entry count and control state; entry contents stay undefined until written
module array_search_insert_delete_unit import asid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	asid_req_if.sink   req,
	asid_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_LIN, S_BIN_RD, S_BIN_CMP, S_INS, S_INS_WR,
		S_DEL, S_DEL_END, S_RD, S_RD_WAIT, S_DONE
	} state_t;

	state_t                    state_q;
	data_t                     key_q;
	logic [IDX_W-1:0]          pos_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          ptr_q;
	logic                      issue_q;
	logic signed [BND_W-1:0]   lo_q;
	logic signed [BND_W-1:0]   hi_q;
	logic [ST_W-1:0]           res_status_q;
	logic [IDX_W-1:0]          res_index_q;
	logic [ELEM_W-1:0]         res_elem_q;
	logic                      out_valid_q;
	logic [ST_W-1:0]           out_status_q;
	logic [INDEX_W-1:0]        out_index_q;
	logic [ELEM_W-1:0]         out_elem_q;
	logic [TOTAL_W-1:0]        out_total_q;

	// entry memory and its read stage
	data_t                     mem_q [CAPACITY];
	logic                      rv_s1;
	logic [IDX_W-1:0]          ridx_s1;
	data_t                     rdata_s1;

	logic                      re;
	logic [IDX_W-1:0]          raddr;
	logic                      we;
	logic [IDX_W-1:0]          waddr;
	data_t                     wdata;

	logic [IDX_W-1:0]          last_idx;
	logic [BND_W-1:0]          mid_sum;
	logic [IDX_W-1:0]          mid_idx;
	logic                      key_eq;
	logic                      key_lt;
	logic signed [BND_W-1:0]   mid_ext;
	logic signed [BND_W-1:0]   lo_nx;
	logic signed [BND_W-1:0]   hi_nx;
	logic                      bin_more;

	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

	// binary search probe and narrowing
	assign mid_sum  = BND_W'(lo_q) + BND_W'(hi_q);
	assign mid_idx  = mid_sum[IDX_W:1];
	assign key_eq   = (rdata_s1 == key_q);
	assign key_lt   = ($signed(rdata_s1) < $signed(key_q));
	assign mid_ext  = $signed(BND_W'(ridx_s1));
	assign lo_nx    = key_lt ? mid_ext + BND_W'(1) : lo_q;
	assign hi_nx    = key_lt ? hi_q : mid_ext - BND_W'(1);
	assign bin_more = (lo_nx <= hi_nx);

	// memory access selection
	always_comb begin
		re    = 1'b0;
		raddr = ptr_q;
		we    = 1'b0;
		waddr = ridx_s1;
		wdata = rdata_s1;
		case (state_q)
			S_LIN: begin
				re = issue_q;
			end
			S_BIN_RD: begin
				re    = 1'b1;
				raddr = mid_idx;
			end
			S_INS: begin
				re    = issue_q;
				we    = rv_s1;
				waddr = ridx_s1 + IDX_W'(1);
			end
			S_INS_WR: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = key_q;
			end
			S_DEL: begin
				re    = issue_q;
				we    = rv_s1 && (ridx_s1 != pos_q);
				waddr = ridx_s1 - IDX_W'(1);
			end
			S_RD: begin
				re    = 1'b1;
				raddr = pos_q;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// entry memory with separate read and write ports, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
			ridx_s1  <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= re;
		end
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			key_q        <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			issue_q      <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			res_status_q <= ST_OK;
			res_index_q  <= '0;
			res_elem_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_index_q  <= '0;
			out_elem_q   <= '0;
			out_total_q  <= '0;
		end else begin
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						key_q       <= fit_key(req.key_or_value);
						pos_q       <= IDX_W'(req.position);
						res_index_q <= '0;
						res_elem_q  <= '0;
						case (req.op)
							OP_LINEAR: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_NOT_FOUND;
									state_q      <= S_DONE;
								end else begin
									ptr_q   <= '0;
									issue_q <= 1'b1;
									state_q <= S_LIN;
								end
							end
							OP_BINARY: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_NOT_FOUND;
									state_q      <= S_DONE;
								end else begin
									lo_q    <= '0;
									hi_q    <= $signed(BND_W'(cnt_q)) - BND_W'(1);
									state_q <= S_BIN_RD;
								end
							end
							OP_INSERT: begin
								if (int'(cnt_q) >= CAPACITY) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else if (int'(req.position) > int'(cnt_q)) begin
									res_status_q <= ST_BAD_POS;
									state_q      <= S_DONE;
								end else if (int'(req.position) == int'(cnt_q)) begin
									state_q <= S_INS_WR;
								end else begin
									ptr_q   <= last_idx;
									issue_q <= 1'b1;
									state_q <= S_INS;
								end
							end
							OP_DELETE: begin
								if (int'(req.position) >= int'(cnt_q)) begin
									res_status_q <= ST_BAD_POS;
									state_q      <= S_DONE;
								end else begin
									ptr_q   <= IDX_W'(req.position);
									issue_q <= 1'b1;
									state_q <= S_DEL;
								end
							end
							OP_READ: begin
								if (int'(req.position) >= int'(cnt_q)) begin
									res_status_q <= ST_BAD_POS;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								res_status_q <= ST_BAD_POS;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				// stream reads upward, compare on the registered read data
				S_LIN: begin
					if (issue_q) begin
						ptr_q <= ptr_q + IDX_W'(1);
						if (ptr_q == last_idx) begin
							issue_q <= 1'b0;
						end
					end
					if (rv_s1 && key_eq) begin
						res_status_q <= ST_OK;
						res_index_q  <= ridx_s1;
						state_q      <= S_DONE;
					end else if (rv_s1 && (ridx_s1 == last_idx)) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				S_BIN_RD: begin
					state_q <= S_BIN_CMP;
				end
				S_BIN_CMP: begin
					if (key_eq) begin
						res_status_q <= ST_OK;
						res_index_q  <= ridx_s1;
						state_q      <= S_DONE;
					end else begin
						lo_q <= lo_nx;
						hi_q <= hi_nx;
						if (bin_more) begin
							state_q <= S_BIN_RD;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					end
				end
				// shift entries up from the top, then store the new value
				S_INS: begin
					if (issue_q) begin
						ptr_q <= ptr_q - IDX_W'(1);
						if (ptr_q == pos_q) begin
							issue_q <= 1'b0;
						end
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					cnt_q        <= cnt_q + CNT_W'(1);
					res_status_q <= ST_OK;
					res_index_q  <= pos_q;
					state_q      <= S_DONE;
				end
				// capture the removed entry, shift the rest down
				S_DEL: begin
					if (issue_q) begin
						ptr_q <= ptr_q + IDX_W'(1);
						if (ptr_q == last_idx) begin
							issue_q <= 1'b0;
						end
					end else begin
						state_q <= S_DEL_END;
					end
					if (rv_s1 && (ridx_s1 == pos_q)) begin
						res_elem_q <= elem_of(rdata_s1);
					end
				end
				S_DEL_END: begin
					cnt_q        <= cnt_q - CNT_W'(1);
					res_status_q <= ST_OK;
					res_index_q  <= pos_q;
					state_q      <= S_DONE;
				end
				S_RD: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					res_elem_q   <= elem_of(rdata_s1);
					res_status_q <= ST_OK;
					res_index_q  <= pos_q;
					state_q      <= S_DONE;
				end
				// hand the result over once the output register is free
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= INDEX_W'(res_index_q);
						out_elem_q   <= res_elem_q;
						out_total_q  <= TOTAL_W'(cnt_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.index       = out_index_q;
	assign rsp.element     = out_elem_q;
	assign rsp.entry_total = out_total_q;

endmodule

// ----- hdl/asid_checker.sv -----
// port-level checks of the array search unit, bound to the top level
// depends on asid_pkg and array_search_insert_delete_unit_assert.svh
`include "array_search_insert_delete_unit_assert.svh"

module asid_checker import asid_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [ST_W-1:0]    rsp_status,
	input logic [ELEM_W-1:0]  rsp_element,
	input logic [TOTAL_W-1:0] rsp_entry_total
);

	// a pending response stays until taken
	`ASID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// one request in work at a time
	`ASID_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)

	// failed operations carry no element
	`ASID_ASSERT_NOW(a_fail_no_elem, rsp_valid && (rsp_status != ST_OK), rsp_element == '0)

	// full status only with every entry in use
	`ASID_ASSERT_NOW(a_full_total, rsp_valid && (rsp_status == ST_FULL),
		rsp_entry_total == TOTAL_W'(CAPACITY))

	// count never beyond capacity
	`ASID_ASSERT_NOW(a_total_range, rsp_valid, int'(rsp_entry_total) <= CAPACITY)

endmodule

bind array_search_insert_delete_unit asid_checker u_asid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_element     (rsp.element),
	.rsp_entry_total (rsp.entry_total)
);
